// File: rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, character codes and helper functions for the tagged count
// line parser.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // default width of a count value
    localparam int CNT_BITS_DEF  = 24;
    // widest accumulator any legal count width needs (count width up to 31)
    localparam int VAL_MAX_W     = 32;
    // reset value of the largest accepted count
    localparam int MAX_COUNT_RST = 100000;

    // character codes
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // tag matcher phase
    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_SIGN   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_FOUND  = 6'b010000,
        PH_FAILED = 6'b100000
    } t_phase;

    // first digit run phase
    typedef enum logic [2:0] {
        FB_NONE = 3'b001,
        FB_RUN  = 3'b010,
        FB_DONE = 3'b100
    } t_fb_phase;

    // line-end status of one tag matcher
    typedef struct packed {
        logic has_num;
        logic in_range;
    } t_match_res;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_COLON) || (c == CH_COMMA) || (c == CH_EQUAL) ||
               (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // value * 10 + digit, held at sat once it passes sat
    function automatic logic [VAL_MAX_W-1:0] acc_digit(
        input logic [VAL_MAX_W-1:0] v,
        input logic [7:0]           c,
        input logic [VAL_MAX_W-1:0] sat
    );
        logic [VAL_MAX_W+3:0] v_ext;
        logic [VAL_MAX_W+3:0] n;
        v_ext = {4'b0000, v};
        n = (v_ext << 3) + (v_ext << 1) + {{(VAL_MAX_W-4){1'b0}}, 8'(c - CH_ZERO)};
        if (n > {4'b0000, sat}) begin
            return sat;
        end
        return n[VAL_MAX_W-1:0];
    endfunction

endpackage

// File: rtl/tagged_count_line_parser_unit.sv
// ----------------------------------------------------------------------------
// tagged_count_line_parser_unit
// Parses text lines byte by byte for a tagged per-minute count and an
// optional tagged per-second count, one result word per line.
// ----------------------------------------------------------------------------
//  channel   | direction | moves
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one line byte per word, tlast on the final byte
//  m_axis    | out       | one result word per line (counts and flags)
//  cfg       | in        | largest accepted count
//
//  One byte is taken per cycle unless a result waits at the output; a
//  line's result passes the input register, then the matcher update into
//  the result register. Reset clears all matchers and loads the largest
//  count with its default. A stalled result register holds the whole pipe,
//  so input ready follows output ready while a result waits.
// ----------------------------------------------------------------------------
module tagged_count_line_parser_unit import tcl_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF,
    localparam int TDATA_W   = ((2 * COUNT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input byte stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_in
    input  logic                  s_axis_tlast,   // last_char
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // cpm, then cps, zero padded
    output logic [1:0]            m_axis_tuser,   // [0] line_ok, [1] cps_ok
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);

    logic                  en;
    logic                  step;
    logic                  r_in_valid;
    logic [7:0]            r_char;
    logic                  r_last;
    logic [COUNT_BITS-1:0] r_max;
    t_match_res            min_res;
    t_match_res            sec_res;
    logic [COUNT_BITS:0]   min_value;
    logic [COUNT_BITS:0]   sec_value;
    logic                  fb_seen;
    logic [COUNT_BITS:0]   fb_value;
    logic                  line_ok;
    logic                  cps_ok;
    logic [COUNT_BITS-1:0] cpm;
    logic [COUNT_BITS-1:0] cps;
    logic                  r_out_valid;
    logic                  r_line_ok;
    logic                  r_cps_ok;
    logic [COUNT_BITS-1:0] r_cpm;
    logic [COUNT_BITS-1:0] r_cps;

    // pipe advances unless a result is stuck at the output
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign step          = en && r_in_valid;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= COUNT_BITS'(MAX_COUNT_RST);
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && s_axis_tvalid) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    // per-minute tag
    tcl_matcher #(
        .COUNT_BITS (COUNT_BITS),
        .TAG        (CH_M)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_last  (r_last),
        .i_max   (r_max),
        .o_res   (min_res),
        .o_value (min_value)
    );

    // per-second tag
    tcl_matcher #(
        .COUNT_BITS (COUNT_BITS),
        .TAG        (CH_S)
    ) u_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_last  (r_last),
        .i_max   (r_max),
        .o_res   (sec_res),
        .o_value (sec_value)
    );

    // first digit run, used when the minute tag gives no number
    tcl_digit_run #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_last  (r_last),
        .i_max   (r_max),
        .o_seen  (fb_seen),
        .o_value (fb_value)
    );

    // line result selection
    always_comb begin
        if (min_res.has_num) begin
            line_ok = min_res.in_range;
            cpm     = min_value[COUNT_BITS-1:0];
        end else begin
            line_ok = fb_seen && (fb_value <= {1'b0, r_max});
            cpm     = fb_value[COUNT_BITS-1:0];
        end
        cps_ok = line_ok && sec_res.has_num && sec_res.in_range;
        cps    = sec_value[COUNT_BITS-1:0];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= step && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_last) begin
            r_line_ok <= line_ok;
            r_cps_ok  <= cps_ok;
            r_cpm     <= line_ok ? cpm : '0;
            r_cps     <= cps_ok ? cps : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_cps, r_cpm});
    assign m_axis_tuser  = {r_cps_ok, r_line_ok};

endmodule

// File: rtl/tcl_matcher.sv
// ----------------------------------------------------------------------------
// tcl_matcher
// Finds the first "CP" plus tag letter on a line, skips separators, then
// reads an optional minus sign and a saturating decimal number.
// ----------------------------------------------------------------------------
module tcl_matcher import tcl_pkg::*; #(
    parameter int         COUNT_BITS = CNT_BITS_DEF,
    parameter logic [7:0] TAG        = CH_M
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic [COUNT_BITS-1:0] i_max,
    output t_match_res            o_res,
    output logic [COUNT_BITS:0]   o_value
);

    localparam int VAL_W = COUNT_BITS + 1;

    logic [1:0]       r_match, n_match;
    t_phase           r_phase, n_phase;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_neg,   n_neg;
    logic [VAL_MAX_W-1:0] sat;
    logic [VAL_W-1:0] acc_cont;
    logic [VAL_W-1:0] acc_first;

    // saturation point and digit accumulation
    assign sat       = VAL_MAX_W'(i_max) + VAL_MAX_W'(1);
    assign acc_cont  = VAL_W'(acc_digit(VAL_MAX_W'(r_value), i_char, sat));
    assign acc_first = VAL_W'(acc_digit('0, i_char, sat));

    // next state for one byte
    always_comb begin
        n_match = r_match;
        n_phase = r_phase;
        n_value = r_value;
        n_neg   = r_neg;
        unique case (r_phase)
            PH_SEARCH: begin
                if (r_match == 2'd2 && i_char == TAG) begin
                    n_match = 2'd0;
                    n_phase = PH_SKIP;
                end else if (i_char == CH_C) begin
                    n_match = 2'd1;
                end else if (r_match == 2'd1 && i_char == CH_P) begin
                    n_match = 2'd2;
                end else begin
                    n_match = 2'd0;
                end
            end
            PH_SKIP: begin
                if (is_sep(i_char)) begin
                    n_phase = PH_SKIP;
                end else if (i_char == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_value = '0;
                    n_phase = PH_SIGN;
                end else if (is_dec(i_char)) begin
                    n_value = acc_first;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_FAILED;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (is_dec(i_char)) begin
                    n_value = acc_cont;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_FOUND;
                end
            end
            PH_FOUND, PH_FAILED: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase
    end

    // line-end status from the state after this byte
    assign o_res.has_num  = (n_phase == PH_SIGN) || (n_phase == PH_DIGITS) ||
                            (n_phase == PH_FOUND);
    assign o_res.in_range = !(n_neg && (n_value != '0)) && (n_value <= {1'b0, i_max});
    assign o_value        = n_value;

    // state registers, cleared at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 2'd0;
            r_phase <= PH_SEARCH;
            r_value <= '0;
            r_neg   <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_match <= 2'd0;
                r_phase <= PH_SEARCH;
                r_value <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_match <= n_match;
                r_phase <= n_phase;
                r_value <= n_value;
                r_neg   <= n_neg;
            end
        end
    end

endmodule

// File: rtl/tcl_digit_run.sv
// ----------------------------------------------------------------------------
// tcl_digit_run
// Keeps the saturating value of the first run of decimal digits on a line.
// ----------------------------------------------------------------------------
module tcl_digit_run import tcl_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic [COUNT_BITS-1:0] i_max,
    output logic                  o_seen,
    output logic [COUNT_BITS:0]   o_value
);

    localparam int VAL_W = COUNT_BITS + 1;

    t_fb_phase        r_phase, n_phase;
    logic [VAL_W-1:0] r_value, n_value;
    logic [VAL_MAX_W-1:0] sat;

    assign sat = VAL_MAX_W'(i_max) + VAL_MAX_W'(1);

    // next state for one byte
    always_comb begin
        n_phase = r_phase;
        n_value = r_value;
        unique case (r_phase)
            FB_NONE: begin
                if (is_dec(i_char)) begin
                    n_value = VAL_W'(acc_digit('0, i_char, sat));
                    n_phase = FB_RUN;
                end
            end
            FB_RUN: begin
                if (is_dec(i_char)) begin
                    n_value = VAL_W'(acc_digit(VAL_MAX_W'(r_value), i_char, sat));
                end else begin
                    n_phase = FB_DONE;
                end
            end
            FB_DONE: begin
                n_phase = FB_DONE;
            end
            default: begin
                n_phase = FB_NONE;
            end
        endcase
    end

    assign o_seen  = (n_phase != FB_NONE);
    assign o_value = n_value;

    // state registers, cleared at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= FB_NONE;
            r_value <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase <= FB_NONE;
                r_value <= '0;
            end else begin
                r_phase <= n_phase;
                r_value <= n_value;
            end
        end
    end

endmodule
